// ===== sv/crcflp_pkg.sv =====
// Package for the CRC-16 length-prefixed frame parser.
// Holds phase and event codes, register indexes, the config type and the CRC step.
// No dependencies.
package crcflp_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
   localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
   localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd2;

   localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
   localparam logic [7:0]  HEADER_SECOND_RST = 8'h55;
   localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1024;

   localparam logic [2:0] PH_H1   = 3'd0;
   localparam logic [2:0] PH_H2   = 3'd1;
   localparam logic [2:0] PH_CMD  = 3'd2;
   localparam logic [2:0] PH_LENH = 3'd3;
   localparam logic [2:0] PH_LENL = 3'd4;
   localparam logic [2:0] PH_PAY  = 3'd5;
   localparam logic [2:0] PH_CRCH = 3'd6;
   localparam logic [2:0] PH_CRCL = 3'd7;

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_PAYLOAD    = 3'd1;
   localparam logic [2:0] EV_GOOD       = 3'd2;
   localparam logic [2:0] EV_BAD_HEADER = 3'd3;
   localparam logic [2:0] EV_BAD_LENGTH = 3'd4;
   localparam logic [2:0] EV_CRC_ERROR  = 3'd5;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  header_first;
      logic [7:0]  header_second;
      logic [15:0] max_payload;
   } cfg_type;

   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/crcflp_csr.sv =====
// Configuration register file of the frame parser, APB-style access.
// Depends on crcflp_pkg for register indexes, reset values and cfg_type.
module crcflp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [crcflp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [crcflp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [crcflp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready,
   output crcflp_pkg::cfg_type                   cfg
);

   crcflp_pkg::cfg_type cfg_ff;
   crcflp_pkg::cfg_type cfg_in;
   logic                wr_en;
   logic [1:0]          reg_idx;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            crcflp_pkg::REG_HEADER_FIRST:  cfg_in.header_first  = csr_pwdata[7:0];
            crcflp_pkg::REG_HEADER_SECOND: cfg_in.header_second = csr_pwdata[7:0];
            crcflp_pkg::REG_MAX_PAYLOAD:   cfg_in.max_payload   = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= crcflp_pkg::HEADER_FIRST_RST;
         cfg_ff.header_second <= crcflp_pkg::HEADER_SECOND_RST;
         cfg_ff.max_payload   <= crcflp_pkg::MAX_PAYLOAD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         crcflp_pkg::REG_HEADER_FIRST:  csr_prdata = {24'd0, cfg_ff.header_first};
         crcflp_pkg::REG_HEADER_SECOND: csr_prdata = {24'd0, cfg_ff.header_second};
         crcflp_pkg::REG_MAX_PAYLOAD:   csr_prdata = {16'd0, cfg_ff.max_payload};
         default:                       csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== sv/crcflp_core.sv =====
// Frame parser datapath: phase machine, running CRC and the result register.
// Depends on crcflp_pkg for codes, cfg_type and the CRC byte step.
module crcflp_core (
   input  logic                clock,
   input  logic                reset,
   input  crcflp_pkg::cfg_type cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_event_res,
   output logic [7:0]          rsp_frame_cmd,
   output logic [15:0]         rsp_frame_length,
   output logic [7:0]          rsp_payload_byte
);

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crch_ff, crch_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  event_ff, event_in;
   logic [7:0]  rcmd_ff;
   logic [15:0] rlength_ff;
   logic [7:0]  pay_ff, pay_in;

   logic        accept;
   logic [15:0] crc_step;
   logic [15:0] left_dec;

   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign crc_step  = crcflp_pkg::crc_add_byte(crc_ff, req_in_byte);
   assign left_dec  = left_ff - 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      length_in = length_ff;
      left_in   = left_ff;
      crc_in    = crc_ff;
      crch_in   = crch_ff;
      event_in  = crcflp_pkg::EV_NONE;
      pay_in    = 8'd0;
      case (phase_ff)
         crcflp_pkg::PH_H1: begin
            if (req_in_byte == cfg.header_first) begin
               phase_in = crcflp_pkg::PH_H2;
            end else begin
               event_in = crcflp_pkg::EV_BAD_HEADER;
            end
         end
         crcflp_pkg::PH_H2: begin
            if (req_in_byte == cfg.header_second) begin
               phase_in = crcflp_pkg::PH_CMD;
               crc_in   = crcflp_pkg::CRC_INIT;
            end else begin
               event_in = crcflp_pkg::EV_BAD_HEADER;
               phase_in = crcflp_pkg::PH_H1;
            end
         end
         crcflp_pkg::PH_CMD: begin
            cmd_in   = req_in_byte;
            crc_in   = crc_step;
            phase_in = crcflp_pkg::PH_LENH;
         end
         crcflp_pkg::PH_LENH: begin
            length_in = {req_in_byte, 8'd0};
            crc_in    = crc_step;
            phase_in  = crcflp_pkg::PH_LENL;
         end
         crcflp_pkg::PH_LENL: begin
            length_in = {length_ff[15:8], req_in_byte};
            crc_in    = crc_step;
            if (length_in > cfg.max_payload) begin
               event_in = crcflp_pkg::EV_BAD_LENGTH;
               phase_in = crcflp_pkg::PH_H1;
            end else if (length_in == 16'd0) begin
               phase_in = crcflp_pkg::PH_CRCH;
            end else begin
               left_in  = length_in;
               phase_in = crcflp_pkg::PH_PAY;
            end
         end
         crcflp_pkg::PH_PAY: begin
            event_in = crcflp_pkg::EV_PAYLOAD;
            pay_in   = req_in_byte;
            crc_in   = crc_step;
            left_in  = left_dec;
            if (left_dec == 16'd0) begin
               phase_in = crcflp_pkg::PH_CRCH;
            end
         end
         crcflp_pkg::PH_CRCH: begin
            crch_in  = req_in_byte;
            phase_in = crcflp_pkg::PH_CRCL;
         end
         default: begin
            if ({crch_ff, req_in_byte} == crc_ff) begin
               event_in = crcflp_pkg::EV_GOOD;
            end else begin
               event_in = crcflp_pkg::EV_CRC_ERROR;
            end
            phase_in = crcflp_pkg::PH_H1;
         end
      endcase
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= crcflp_pkg::PH_H1;
         cmd_ff       <= 8'd0;
         length_ff    <= 16'd0;
         left_ff      <= 16'd0;
         crc_ff       <= crcflp_pkg::CRC_INIT;
         crch_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            cmd_ff    <= cmd_in;
            length_ff <= length_in;
            left_ff   <= left_in;
            crc_ff    <= crc_in;
            crch_ff   <= crch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff   <= event_in;
         rcmd_ff    <= cmd_in;
         rlength_ff <= length_in;
         pay_ff     <= pay_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = event_ff;
   assign rsp_frame_cmd    = rcmd_ff;
   assign rsp_frame_length = rlength_ff;
   assign rsp_payload_byte = pay_ff;

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && event_ff != crcflp_pkg::EV_PAYLOAD) |-> pay_ff == 8'd0)
      else $error("payload byte set on non-payload event");

   a_pay_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == crcflp_pkg::PH_PAY |-> left_ff != 16'd0)
      else $error("payload phase with no bytes left");

   a_crcl_returns: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == crcflp_pkg::PH_CRCL) |=> phase_ff == crcflp_pkg::PH_H1)
      else $error("no return to hunting after CRC low byte");

endmodule

// ===== sv/crc16_length_frame_parser_top.sv =====
// Top level of the CRC-16 length-prefixed frame parser.
// Depends on crcflp_pkg, crcflp_csr and crcflp_core.
//
// Usage:
//   req_* carries one received byte per item; rsp_* returns exactly one
//   result item per input item: event code, command and length of the
//   current frame, and the payload byte on payload events.
//   csr_* is an APB-style port: header_first at 0x0, header_second at 0x4,
//   max_payload at 0x8. Write only while the parser is idle.
// Timing and throughput:
//   An item's result is registered and shows in the cycle after acceptance.
//   One item per cycle is sustained unless stalled; the byte-wide CRC step
//   and the phase update settle between the state and result registers.
// Reset:
//   Synchronous. The parser hunts for the first header byte, the CRC is
//   0xFFFF, registers take 0xAA, 0x55 and 1024. req_stall is high in reset.
// Backpressure:
//   While rsp_valid is high and rsp_stall is high the result holds and
//   req_stall is raised; a result being taken lets a new item in that cycle.
module crc16_length_frame_parser_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_in_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_event_res,
   output logic [7:0]                        rsp_frame_cmd,
   output logic [15:0]                       rsp_frame_length,
   output logic [7:0]                        rsp_payload_byte,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crcflp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [crcflp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [crcflp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);

   crcflp_pkg::cfg_type cfg;

   crcflp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   crcflp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_frame_cmd    (rsp_frame_cmd),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload_byte (rsp_payload_byte)
   );

endmodule

// ===== sim/crc16_length_frame_parser_top_test.sv =====
// Self-checking testbench for crc16_length_frame_parser_top: byte stream in, one event per byte.
// A bytewise deframer with its own CRC-16 tracks every accepted byte and checks each result item.
// Depends on crcflp_pkg and crc16_length_frame_parser_top.
module crc16_length_frame_parser_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int ROUND_ITEMS = 280;

   typedef struct packed {
      logic [2:0]  ev;
      logic [7:0]  cmd;
      logic [15:0] len;
      logic [7:0]  pay;
   } frame_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [7:0]                        req_in_byte = 8'h00;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [2:0]                        rsp_event_res;
   logic [7:0]                        rsp_frame_cmd;
   logic [15:0]                       rsp_frame_length;
   logic [7:0]                        rsp_payload_byte;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [crcflp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [crcflp_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [crcflp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   logic [7:0]  hdr_first = crcflp_pkg::HEADER_FIRST_RST;
   logic [7:0]  hdr_second = crcflp_pkg::HEADER_SECOND_RST;
   logic [15:0] max_len = crcflp_pkg::MAX_PAYLOAD_RST;

   logic [2:0]  parse_phase = crcflp_pkg::PH_H1;
   logic [7:0]  cur_cmd = 8'h00;
   logic [15:0] cur_len = 16'h0000;
   logic [15:0] payload_left = 16'h0000;
   logic [15:0] crc_acc = crcflp_pkg::CRC_INIT;
   logic [7:0]  crc_upper = 8'h00;

   logic [7:0]       byte_backlog[$];
   frame_result_type predicted_results[$];
   bit               steady = 1'b0;
   int               errors = 0;
   int               loaded_items = 0;
   int               items_taken = 0;
   int               results_seen = 0;
   int               quiet_cycles = 0;
   int               event_tally[8];

   crc16_length_frame_parser_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_frame_cmd    (rsp_frame_cmd),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload_byte (rsp_payload_byte),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ crcflp_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic frame_result_type parse_byte(input logic [7:0] b);
      frame_result_type r;
      r.ev = crcflp_pkg::EV_NONE;
      r.pay = 8'h00;
      case (parse_phase)
         crcflp_pkg::PH_H1: begin
            if (b == hdr_first) begin
               parse_phase = crcflp_pkg::PH_H2;
            end else begin
               r.ev = crcflp_pkg::EV_BAD_HEADER;
            end
         end
         crcflp_pkg::PH_H2: begin
            if (b == hdr_second) begin
               parse_phase = crcflp_pkg::PH_CMD;
               crc_acc = crcflp_pkg::CRC_INIT;
            end else begin
               r.ev = crcflp_pkg::EV_BAD_HEADER;
               parse_phase = crcflp_pkg::PH_H1;
            end
         end
         crcflp_pkg::PH_CMD: begin
            cur_cmd = b;
            crc_acc = crc_ccitt_step(crc_acc, b);
            parse_phase = crcflp_pkg::PH_LENH;
         end
         crcflp_pkg::PH_LENH: begin
            cur_len = {b, 8'h00};
            crc_acc = crc_ccitt_step(crc_acc, b);
            parse_phase = crcflp_pkg::PH_LENL;
         end
         crcflp_pkg::PH_LENL: begin
            cur_len[7:0] = b;
            crc_acc = crc_ccitt_step(crc_acc, b);
            if (cur_len > max_len) begin
               r.ev = crcflp_pkg::EV_BAD_LENGTH;
               parse_phase = crcflp_pkg::PH_H1;
            end else if (cur_len == 16'h0000) begin
               parse_phase = crcflp_pkg::PH_CRCH;
            end else begin
               payload_left = cur_len;
               parse_phase = crcflp_pkg::PH_PAY;
            end
         end
         crcflp_pkg::PH_PAY: begin
            r.ev = crcflp_pkg::EV_PAYLOAD;
            r.pay = b;
            crc_acc = crc_ccitt_step(crc_acc, b);
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'h0000) begin
               parse_phase = crcflp_pkg::PH_CRCH;
            end
         end
         crcflp_pkg::PH_CRCH: begin
            crc_upper = b;
            parse_phase = crcflp_pkg::PH_CRCL;
         end
         default: begin
            r.ev = ({crc_upper, b} == crc_acc) ? crcflp_pkg::EV_GOOD : crcflp_pkg::EV_CRC_ERROR;
            parse_phase = crcflp_pkg::PH_H1;
         end
      endcase
      r.cmd = cur_cmd;
      r.len = cur_len;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_results.push_back(parse_byte(req_in_byte));
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_backlog.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
               req_valid <= 1'b1;
               req_in_byte <= byte_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      frame_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
               want = predicted_results.pop_front();
               event_tally[want.ev]++;
               if (rsp_event_res !== want.ev)
                  report_mismatch($sformatf("result %0d event_res %0h, want %0h",
                                            results_seen, rsp_event_res, want.ev));
               if (rsp_frame_cmd !== want.cmd)
                  report_mismatch($sformatf("result %0d frame_cmd %0h, want %0h",
                                            results_seen, rsp_frame_cmd, want.cmd));
               if (rsp_frame_length !== want.len)
                  report_mismatch($sformatf("result %0d frame_length %0h, want %0h",
                                            results_seen, rsp_frame_length, want.len));
               if (rsp_payload_byte !== want.pay)
                  report_mismatch($sformatf("result %0d payload_byte %0h, want %0h",
                                            results_seen, rsp_payload_byte, want.pay));
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 19);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("crc16_length_frame_parser_top_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic load_byte(input logic [7:0] b);
      byte_backlog.push_back(b);
      loaded_items++;
   endtask

   task automatic push_frame(input logic [7:0] cmd, input logic [15:0] len,
                             input logic [7:0] body[$], input bit corrupt);
      logic [15:0] crc;
      load_byte(hdr_first);
      load_byte(hdr_second);
      load_byte(cmd);
      load_byte(len[15:8]);
      load_byte(len[7:0]);
      crc = crc_ccitt_step(crcflp_pkg::CRC_INIT, cmd);
      crc = crc_ccitt_step(crc_ccitt_step(crc, len[15:8]), len[7:0]);
      if (len <= max_len) begin
         foreach (body[i]) begin
            load_byte(body[i]);
            crc = crc_ccitt_step(crc, body[i]);
         end
         if (corrupt) begin
            crc = crc ^ (16'd1 << $urandom_range(15));
         end
         load_byte(crc[15:8]);
         load_byte(crc[7:0]);
      end
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (byte_backlog.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] want;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= crcflp_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         crcflp_pkg::REG_HEADER_FIRST: begin
            hdr_first = val[7:0];
            want = {24'h0, val[7:0]};
         end
         crcflp_pkg::REG_HEADER_SECOND: begin
            hdr_second = val[7:0];
            want = {24'h0, val[7:0]};
         end
         default: begin
            max_len = val[15:0];
            want = {16'h0, val[15:0]};
         end
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, csr_prdata, want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0]  body[$];
      logic [7:0]  set_first[6];
      logic [7:0]  set_second[6];
      logic [15:0] set_max[6];
      logic [15:0] len;
      logic [15:0] cap;
      logic [7:0]  v;
      int          pick;
      int          round_start;

      set_first = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'hAA, 8'h3C};
      set_second = '{8'hFF, 8'h00, 8'h5A, 8'h00, 8'h55, 8'hC3};
      set_max = '{16'd0, 16'hFFFF, 16'd16, 16'd0, 16'd1024, 16'd255};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // headers, second header mismatch on a first-header byte, zero length,
      // oversize length, two-byte payload with a broken checksum
      load_byte(8'h00);
      load_byte(hdr_first);
      load_byte(hdr_first);
      body.delete();
      push_frame(8'hFF, 16'h0000, body, 1'b0);
      push_frame(8'h00, 16'hFFFF, body, 1'b0);
      body = '{8'h00, 8'hFF};
      push_frame(8'h5A, 16'd2, body, 1'b1);

      set_first[3] = 8'($urandom_range(255));
      set_second[3] = 8'($urandom_range(255));
      set_max[3] = 16'($urandom_range(64, 1));

      for (int r = 0; r < 6; r++) begin
         wait_drained();
         program_reg(crcflp_pkg::REG_HEADER_FIRST, {24'h0, set_first[r]});
         program_reg(crcflp_pkg::REG_HEADER_SECOND, {24'h0, set_second[r]});
         program_reg(crcflp_pkg::REG_MAX_PAYLOAD, {16'h0, set_max[r]});
         steady = (r == 4);
         round_start = loaded_items;
         while (loaded_items - round_start < ROUND_ITEMS) begin
            pick = $urandom_range(99);
            cap = (max_len < 16'd12) ? max_len : 16'd12;
            if ($urandom_range(19) == 0) begin
               cap = (max_len < 16'd48) ? max_len : 16'd48;
            end
            if (pick < 72) begin
               len = 16'($urandom_range(cap, 0));
               body.delete();
               repeat (len) body.push_back(8'($urandom_range(255)));
               push_frame(8'($urandom_range(255)), len, body, pick >= 62);
            end else if (pick < 80 && max_len != 16'hFFFF) begin
               body.delete();
               len = 16'($urandom_range(65535, int'(max_len) + 1));
               push_frame(8'($urandom_range(255)), len, body, 1'b0);
            end else if (pick < 88) begin
               v = 8'($urandom_range(255));
               load_byte(hdr_first);
               load_byte((v == hdr_second) ? ~v : v);
            end else begin
               repeat ($urandom_range(4, 1)) begin
                  v = 8'($urandom_range(255));
                  load_byte((v == hdr_first) ? ~v : v);
               end
            end
         end
      end
      steady = 1'b0;
      wait_drained();

      $display("covered %0d bytes over 7 register settings: %0d good frames, %0d crc errors,",
               items_taken, event_tally[crcflp_pkg::EV_GOOD],
               event_tally[crcflp_pkg::EV_CRC_ERROR]);
      $display("%0d bad headers, %0d bad lengths, %0d payload bytes",
               event_tally[crcflp_pkg::EV_BAD_HEADER], event_tally[crcflp_pkg::EV_BAD_LENGTH],
               event_tally[crcflp_pkg::EV_PAYLOAD]);
      if (errors == 0) begin
         $display("crc16_length_frame_parser_top_test: clean");
      end else begin
         $display("crc16_length_frame_parser_top_test: errors");
      end
      $finish;
   end

endmodule
